// File: sv/bfba_pkg.sv
// Package: types, constants and helpers for the bit-field buffer access block.
package bfba_pkg;

    localparam int STORE_WORDS = 8;
    localparam int WORD_BITS   = 32;
    localparam int START_W     = 8;
    localparam int COUNT_W     = 6;
    localparam int OFF_W       = $clog2(WORD_BITS);
    localparam int PAIR_BITS   = 2 * WORD_BITS;
    localparam int SHIFT_W     = $clog2(PAIR_BITS) + 1;
    localparam int REACH_WORDS = (2 ** START_W) / WORD_BITS;
    localparam int USED_WORDS  = (STORE_WORDS < REACH_WORDS) ? STORE_WORDS : REACH_WORDS;
    localparam int WIDX_W      = $clog2(REACH_WORDS) + 1;
    localparam int BANK_DEPTH  = (USED_WORDS + 1) / 2;
    localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam logic [WORD_BITS-1:0] FULL_MASK = '1;
    localparam logic [COUNT_W-1:0]   MAX_COUNT = COUNT_W'(WORD_BITS);

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_command;

    typedef struct packed {
        t_command               command;
        logic [COUNT_W-1:0]     bit_count;
        logic [START_W-1:0]     start_bit;
        logic [WORD_BITS-1:0]   write_value;
    } t_request;

    typedef struct packed {
        logic [WORD_BITS-1:0]   read_value;
        logic                   length_error;
    } t_result;

    typedef struct packed {
        logic                   en;
        logic [BANK_AW-1:0]     addr;
        logic [WORD_BITS-1:0]   data;
    } t_bank_wr;

    function automatic logic [WIDX_W-1:0] first_word(input logic [START_W-1:0] start_bit);
        return WIDX_W'(start_bit >> OFF_W);
    endfunction

    function automatic logic [WIDX_W-1:0] bank_word(input logic [WIDX_W-1:0] idx,
                                                    input logic bank);
        logic [WIDX_W-1:0] nxt;
        nxt = idx + WIDX_W'(1);
        return (idx[0] == bank) ? idx : nxt;
    endfunction

    function automatic logic [BANK_AW-1:0] bank_addr(input logic [WIDX_W-1:0] word);
        return BANK_AW'(word >> 1);
    endfunction

endpackage

// File: sv/bfba_ram.sv
// Generic single-port-write, registered-read RAM.
module bfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/bfba_bank.sv
// One store bank: RAM, per-entry valid bits and same-cycle write forwarding.
module bfba_bank (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [bfba_pkg::BANK_AW-1:0]   i_rd_addr,
    input  bfba_pkg::t_bank_wr             i_wr,
    output logic [bfba_pkg::WORD_BITS-1:0] o_word
);
    import bfba_pkg::*;

    logic [BANK_DEPTH-1:0] r_valid;
    logic                  r_rd_valid;
    logic                  r_fwd;
    logic [WORD_BITS-1:0]  r_fwd_data;
    logic [WORD_BITS-1:0]  ram_q;

    bfba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BANK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr.en),
        .i_wr_addr (i_wr.addr),
        .i_wr_data (i_wr.data),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[i_rd_addr];
        r_fwd      <= i_wr.en && (i_wr.addr == i_rd_addr);
        r_fwd_data <= i_wr.data;
    end

    // take the word written on the read edge, else the stored word if ever written
    assign o_word = r_fwd      ? r_fwd_data :
                    r_rd_valid ? ram_q      : '0;

endmodule

// File: sv/bit_field_buffer_access.sv
// Top level: MSB-first bit-field read and write on a banked word store.
//
//   channel   | signals                     | transfer
//   ----------+-----------------------------+----------------------------------
//   request   | start, busy, i_request      | taken when start & !busy
//   result    | o_done, o_result            | one-cycle strobe, no back-pressure
//
// One request per cycle; busy stays low. A taken request passes through the registered
// read of the even and odd word banks, then the field extract/splice and the result
// register, which drives the result port.
// Reset is synchronous; it empties the pipeline and clears the per-word valid
// bits, so the store reads as zero at once with no clearing pass.
// The receiver cannot stall; results are never held.
module bit_field_buffer_access (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bfba_pkg::t_request i_request,
    output logic               o_done,
    output bfba_pkg::t_result  o_result
);
    import bfba_pkg::*;

    logic                 r_s1;
    t_request             r_req;
    logic                 r_done;
    t_result              r_result;
    logic                 n_s1;
    t_result              n_result;

    logic [WIDX_W-1:0]    in_idx;
    logic [BANK_AW-1:0]   rd_addr [2];
    logic [WORD_BITS-1:0] bank_q  [2];
    t_bank_wr             bank_wr [2];

    logic [WIDX_W-1:0]    s1_idx;
    logic [WIDX_W-1:0]    s1_idx_hi;
    logic                 lo_in;
    logic                 hi_in;
    logic                 len_ok;
    logic                 do_write;
    logic [OFF_W-1:0]     off;
    logic [SHIFT_W-1:0]   shift;
    logic [WORD_BITS-1:0] fmask;
    logic [WORD_BITS-1:0] lo_data;
    logic [WORD_BITS-1:0] hi_data;
    logic [PAIR_BITS-1:0] pair;
    logic [PAIR_BITS-1:0] m64;
    logic [PAIR_BITS-1:0] new_pair;
    logic [WORD_BITS-1:0] field;

    assign busy   = 1'b0;
    assign n_s1   = start && !busy;
    assign in_idx = first_word(i_request.start_bit);

    for (genvar b = 0; b < 2; b++) begin : g_bank
        assign rd_addr[b] = bank_addr(bank_word(in_idx, 1'(b)));

        bfba_bank u_bank (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_rd_addr (rd_addr[b]),
            .i_wr      (bank_wr[b]),
            .o_word    (bank_q[b])
        );
    end

    always_comb begin
        s1_idx    = first_word(r_req.start_bit);
        s1_idx_hi = s1_idx + WIDX_W'(1);
        lo_in     = s1_idx < WIDX_W'(USED_WORDS);
        hi_in     = s1_idx_hi < WIDX_W'(USED_WORDS);
        len_ok    = (r_req.bit_count != '0) && (r_req.bit_count <= MAX_COUNT);
        do_write  = r_s1 && len_ok && (r_req.command == CMD_WRITE);

        lo_data   = lo_in ? bank_q[s1_idx[0]]  : '0;
        hi_data   = hi_in ? bank_q[!s1_idx[0]] : '0;
        pair      = {lo_data, hi_data};

        off       = r_req.start_bit[OFF_W-1:0];
        shift     = SHIFT_W'(PAIR_BITS) - SHIFT_W'(off) - SHIFT_W'(r_req.bit_count);
        fmask     = FULL_MASK >> (MAX_COUNT - r_req.bit_count);
        field     = WORD_BITS'(pair >> shift) & fmask;
        m64       = {{WORD_BITS{1'b0}}, fmask} << shift;
        new_pair  = (pair & ~m64)
                  | ({{WORD_BITS{1'b0}}, r_req.write_value & fmask} << shift);
    end

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            bank_wr[b].addr = bank_addr(bank_word(s1_idx, b[0]));
            if (s1_idx[0] == b[0]) begin
                bank_wr[b].en   = do_write && lo_in;
                bank_wr[b].data = new_pair[PAIR_BITS-1:WORD_BITS];
            end else begin
                bank_wr[b].en   = do_write && hi_in;
                bank_wr[b].data = new_pair[WORD_BITS-1:0];
            end
        end
    end

    always_comb begin
        n_result.length_error = !len_ok;
        n_result.read_value   = (len_ok && (r_req.command == CMD_READ)) ? field : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= n_s1;
            r_done <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_s1) begin
            r_req <= i_request;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: sv/bfba_checker.sv
// Checker: port-level timing and result properties, bound to the top level.
module bfba_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input bfba_pkg::t_request i_request,
    input logic               o_done,
    input bfba_pkg::t_result  o_result
);
    import bfba_pkg::*;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("request not answered two cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without a matching request");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.length_error) |-> (o_result.read_value == '0))
        else $error("length error with nonzero read value");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(i_request.command, 2) == CMD_WRITE))
            |-> (o_result.read_value == '0))
        else $error("write request returned nonzero read value");

    a_error_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.length_error ==
            (($past(i_request.bit_count, 2) == '0) ||
             ($past(i_request.bit_count, 2) > MAX_COUNT))))
        else $error("length error flag does not match bit count");

endmodule

bind bit_field_buffer_access bfba_checker u_bfba_checker (.*);

// File: verif/bfba_field_checker.sv
// Checker for the bit-field buffer access block: predicts each request's result and compares.
`timescale 1ns / 100ps

module bfba_field_checker
    import bfba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_request i_request,
    input  logic     i_done,
    input  t_result  i_result,
    output int       o_errors,
    output int       o_outstanding
);

    logic [WORD_BITS-1:0] shadow_words [STORE_WORDS];
    t_result              field_results_due [$];

    function automatic logic [WORD_BITS-1:0] shadow_load(input int unsigned word_idx);
        return (word_idx < STORE_WORDS) ? shadow_words[word_idx] : '0;
    endfunction

    function automatic t_result predict_field_access(input t_request rq);
        t_result                res;
        int unsigned            n;
        int unsigned            word_idx;
        int unsigned            off;
        int unsigned            shift;
        logic [WORD_BITS-1:0]   fmask;
        logic [PAIR_BITS-1:0]   pair;
        logic [PAIR_BITS-1:0]   pair_mask;
        res      = '0;
        n        = rq.bit_count;
        if (n == 0 || n > WORD_BITS) begin
            res.length_error = 1'b1;
            return res;
        end
        word_idx = rq.start_bit / WORD_BITS;
        off      = rq.start_bit % WORD_BITS;
        shift    = PAIR_BITS - off - n;
        fmask    = FULL_MASK >> (WORD_BITS - n);
        pair     = {shadow_load(word_idx), shadow_load(word_idx + 1)};
        if (rq.command == CMD_READ) begin
            res.read_value = WORD_BITS'((pair >> shift) & PAIR_BITS'(fmask));
        end else begin
            pair_mask = PAIR_BITS'(fmask) << shift;
            pair      = (pair & ~pair_mask) | (PAIR_BITS'(rq.write_value & fmask) << shift);
            // drop words past the end of the store
            if (word_idx < STORE_WORDS)
                shadow_words[word_idx] = pair[PAIR_BITS-1:WORD_BITS];
            if (word_idx + 1 < STORE_WORDS)
                shadow_words[word_idx + 1] = pair[WORD_BITS-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            foreach (shadow_words[w])
                shadow_words[w] = '0;
            field_results_due.delete();
            o_errors = 0;
        end else begin
            if (i_done) begin
                if (field_results_due.size() == 0) begin
                    $display("%0t: unexpected result read_value=%h length_error=%b",
                             $time, i_result.read_value, i_result.length_error);
                    o_errors = o_errors + 1;
                end else begin
                    due = field_results_due.pop_front();
                    if (i_result.read_value !== due.read_value) begin
                        $display("%0t: read_value mismatch expected=%h actual=%h",
                                 $time, due.read_value, i_result.read_value);
                        o_errors = o_errors + 1;
                    end
                    if (i_result.length_error !== due.length_error) begin
                        $display("%0t: length_error mismatch expected=%b actual=%b",
                                 $time, due.length_error, i_result.length_error);
                        o_errors = o_errors + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                field_results_due.push_back(predict_field_access(i_request));
        end
        o_outstanding = field_results_due.size();
    end

endmodule

// File: verif/tb.sv
// Testbench top for the bit-field buffer access block: clock, reset, request stimulus, verdict.
`timescale 1ns / 100ps

module tb;
    import bfba_pkg::*;

    localparam int RANDOM_REQUESTS = 1500;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_request i_request;
    logic     o_done;
    t_result  o_result;
    int       mismatch_count;
    int       results_outstanding;

    always #5 i_clk = ~i_clk;

    bit_field_buffer_access dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_request (i_request),
        .o_done    (o_done),
        .o_result  (o_result)
    );

    bfba_field_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_request     (i_request),
        .i_done        (o_done),
        .i_result      (o_result),
        .o_errors      (mismatch_count),
        .o_outstanding (results_outstanding)
    );

    function automatic t_request field_request(input t_command cmd, input int n,
                                               input int start_bit,
                                               input logic [WORD_BITS-1:0] value);
        t_request rq;
        rq.command     = cmd;
        rq.bit_count   = COUNT_W'(n);
        rq.start_bit   = START_W'(start_bit);
        rq.write_value = value;
        return rq;
    endfunction

    function automatic t_request random_request();
        t_request rq;
        int       pick;
        rq.command = ($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            rq.bit_count = ($urandom_range(0, 3) == 0) ? '0 : COUNT_W'($urandom_range(33, 63));
        else if (pick < 20)
            rq.bit_count = ($urandom_range(0, 1) == 1) ? COUNT_W'(1) : MAX_COUNT;
        else
            rq.bit_count = COUNT_W'($urandom_range(1, WORD_BITS));
        pick = $urandom_range(0, 99);
        if (pick < 20)
            rq.start_bit = START_W'($urandom_range(224, 255));
        else if (pick < 40)
            rq.start_bit = START_W'($urandom_range(0, 7) * WORD_BITS + $urandom_range(24, 31));
        else
            rq.start_bit = START_W'($urandom_range(0, 255));
        rq.write_value = $urandom();
        return rq;
    endfunction

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic issue_request(input t_request rq);
        @(negedge i_clk);
        start     <= 1'b1;
        i_request <= rq;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    task automatic idle_gap(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start     <= 1'b0;
            i_request <= random_request();
        end
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (results_outstanding != 0)
            @(negedge i_clk);
    endtask

    initial begin
        t_request directed_set [$];
        logic     steady;
        steady    = 1'b0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_request = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_set = '{
            field_request(CMD_READ,   32,   0, 32'h0),
            field_request(CMD_WRITE,  32,   0, 32'hFFFF_FFFF),
            field_request(CMD_READ,   32,   0, 32'h0),
            field_request(CMD_WRITE,  24,  20, 32'h00A5_A5A5),
            field_request(CMD_READ,   32,  16, 32'h0),
            field_request(CMD_WRITE,   0,   0, 32'hFFFF_FFFF),
            field_request(CMD_READ,    0,   8, 32'h0),
            field_request(CMD_WRITE,  33,  40, 32'hFFFF_FFFF),
            field_request(CMD_READ,   63, 255, 32'hFFFF_FFFF),
            field_request(CMD_WRITE,  32, 255, 32'hFFFF_FFFF),
            field_request(CMD_READ,   32, 255, 32'h0),
            field_request(CMD_READ,   32, 224, 32'h0),
            field_request(CMD_WRITE,  32, 224, 32'h1234_5678),
            field_request(CMD_READ,   32, 230, 32'h0),
            field_request(CMD_WRITE,   1,  31, 32'h0),
            field_request(CMD_READ,    1,  31, 32'h0),
            field_request(CMD_READ,    1,   0, 32'h0),
            field_request(CMD_WRITE,  13, 100, 32'hFFFF_FFFF),
            field_request(CMD_READ,   32,  96, 32'h0),
            field_request(CMD_WRITE,  32, 128, 32'hDEAD_BEEF),
            field_request(CMD_READ,   16, 136, 32'h0),
            field_request(CMD_READ,    1, 255, 32'h0),
            field_request(CMD_WRITE,  32,  63, 32'h8000_0001),
            field_request(CMD_READ,   32,  63, 32'h0)
        };
        foreach (directed_set[k]) begin
            issue_request(directed_set[k]);
            idle_gap(pick_gap());
        end
        wait_for_results();

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_REQUESTS / 2)
                wait_for_results();
            issue_request(random_request());
            if (!steady)
                idle_gap(pick_gap());
        end

        wait_for_results();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("** bit_field_buffer_access: PASSED **");
        else
            $display("** bit_field_buffer_access: FAILED **");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** bit_field_buffer_access: FAILED **");
        $finish;
    end

endmodule
